[hdl/r2fft_pkg.sv]
// Package with the shared types, constants and twiddle table of the radix-2 FFT.
`default_nettype none
package r2fft_pkg;
  localparam int MaxLog2 = 6;
  localparam int MaxPoints = 1 << MaxLog2;
  localparam int SampleBits = 16;
  localparam int OutBits = 28;
  localparam int TwBits = 17;
  localparam int AddrBits = MaxLog2;

  typedef logic signed [OutBits-1:0] word_t;
  typedef logic signed [TwBits-1:0] tw_t;

  typedef enum logic [2:0] {
    ST_LOAD, ST_RDU, ST_RDX, ST_MUL, ST_WRU, ST_WRX, ST_OUT
  } state_t;

  localparam logic [1:0] CfgLog2 = 2'd0;
  localparam logic [1:0] CfgInv = 2'd1;

  function automatic tw_t qsine(input logic [4:0] k);
    tw_t r;
    case (k)
      5'd0: r = 17'sd0;      5'd1: r = 17'sd3212;   5'd2: r = 17'sd6393;
      5'd3: r = 17'sd9512;   5'd4: r = 17'sd12540;  5'd5: r = 17'sd15447;
      5'd6: r = 17'sd18205;  5'd7: r = 17'sd20788;  5'd8: r = 17'sd23170;
      5'd9: r = 17'sd25330;  5'd10: r = 17'sd27246; 5'd11: r = 17'sd28899;
      5'd12: r = 17'sd30274; 5'd13: r = 17'sd31357; 5'd14: r = 17'sd32138;
      5'd15: r = 17'sd32610; default: r = 17'sd32768;
    endcase
    return r;
  endfunction

  // Twiddle for index 0..31 of a 64-point table: (cos, -sin).
  function automatic logic [2*TwBits-1:0] twiddle(input logic [4:0] idx);
    tw_t wr, wi;
    if (idx <= 5'd16) begin
      wr = qsine(5'd16 - idx);
      wi = -qsine(idx);
    end else begin
      wr = -qsine(idx - 5'd16);
      wi = -qsine(5'd0 - idx);
    end
    return {wr, wi};
  endfunction

  function automatic logic [AddrBits-1:0] bit_rev(input logic [AddrBits-1:0] i,
                                                  input logic [2:0] l);
    logic [AddrBits-1:0] r;
    r = '0;
    for (int b = 0; b < AddrBits; b++) begin
      if (b < int'(l)) r[int'(l) - 1 - b] = i[b];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

[hdl/r2fft_if.sv]
// Valid/ready stream interfaces for samples and bins.
`default_nettype none
interface r2fft_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] in_re;
  logic signed [15:0] in_im;
  modport source (output valid, in_re, in_im, input ready);
  modport sink (input valid, in_re, in_im, output ready);
endinterface

interface r2fft_out_if;
  logic valid;
  logic ready;
  logic signed [27:0] out_re;
  logic signed [27:0] out_im;
  logic out_last;
  modport source (output valid, out_re, out_im, out_last, input ready);
  modport sink (input valid, out_re, out_im, out_last, output ready);
endinterface
`default_nettype wire

[hdl/r2fft_bfly.sv]
// Registered complex twiddle multiply with rounding, then butterfly add and subtract.
`default_nettype none
module r2fft_bfly
  import r2fft_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  load,
  input  wire logic [4:0] tw_idx,
  input  wire word_t xr,
  input  wire word_t xi,
  input  wire word_t ur,
  input  wire word_t ui,
  output word_t      ar,
  output word_t      ai,
  output word_t      br,
  output word_t      bi
);
  tw_t wr, wi;
  logic signed [45:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [46:0] sr, si;
  word_t tr, ti;

  assign {wr, wi} = twiddle(tw_idx);

  always_ff @(posedge clk) begin
    if (load) begin
      p_rr_r <= 46'(wr * xr);
      p_ii_r <= 46'(wi * xi);
      p_ri_r <= 46'(wr * xi);
      p_ir_r <= 46'(wi * xr);
    end
  end

  assign sr = 47'(p_rr_r) - 47'(p_ii_r) + 47'sd16384;
  assign si = 47'(p_ri_r) + 47'(p_ir_r) + 47'sd16384;
  assign tr = word_t'(sr >>> 15);
  assign ti = word_t'(si >>> 15);
  assign ar = ur + tr;
  assign ai = ui + ti;
  assign br = ur - tr;
  assign bi = ui - ti;
endmodule
`default_nettype wire

[hdl/radix2_fft_core.sv]
// Top level of the in-place radix-2 decimation-in-time FFT.
//   channel | dir | beat payload                 | handshake
//   in      | in  | in_re, in_im (Q1.15)         | valid/ready
//   out     | out | out_re, out_im (28b), last   | valid/ready
//   cfg     | in  | cfg_index, cfg_data          | cfg_we, no wait
// Loading takes one cycle per sample, stored at the bit-reversed address.
// Each butterfly steps through the single-port sample memory in order (read u,
// read x, multiply, write u, write x). Each output bin is a memory read, then
// an out register load; a new read waits while one is pending or while the out
// register is held under backpressure. Reset is synchronous; the memory is
// not cleared.
`default_nettype none
module radix2_fft_core
  import r2fft_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [2:0] cfg_data,
  r2fft_in_if.sink        in_ch,
  r2fft_out_if.source     out_ch
);
  logic [2:0] log2_r;
  logic inv_r;
  state_t state_r, state_nxt;
  logic [AddrBits:0] cnt_r, cnt_nxt;
  logic [2:0] stage_r, stage_nxt;
  logic [AddrBits-1:0] bf_r, bf_nxt;
  logic [2:0] leff;
  logic [AddrBits:0] npts;

  logic [2*OutBits-1:0] mem [MaxPoints];
  logic [2*OutBits-1:0] rd_r;
  logic mem_we;
  logic [AddrBits-1:0] mem_addr;
  logic [2*OutBits-1:0] mem_wd;

  word_t ur_r, ui_r, ar, ai, br, bi;
  logic [AddrBits-1:0] ua, xa, grp, jj, hmask;
  logic [4:0] tw_idx;
  logic rd_pend_r;
  logic [AddrBits:0] oidx_r;
  logic ov_r;
  word_t ore_r, oim_r;
  logic olast_r;
  logic pend_last_r;
  word_t yr, yi;

  assign leff = (log2_r > 3'(MaxLog2)) ? 3'(MaxLog2) : log2_r;
  assign npts = (AddrBits+1)'(1) << leff;

  // Butterfly addressing: h = 2^stage, j = bf mod h, group = bf - j (bf with its low bits cleared).
  assign hmask = AddrBits'((AddrBits+1)'(1) << stage_r) - AddrBits'(1);
  assign jj = bf_r & hmask;
  assign grp = bf_r & ~hmask;
  assign ua = (grp << 1) | jj;
  assign xa = ua | (hmask + AddrBits'(1));
  assign tw_idx = 5'(jj << (3'(MaxLog2 - 1) - stage_r));

  r2fft_bfly u_bfly (
    .clk(clk), .load(state_r == ST_MUL),
    .tw_idx(tw_idx),
    .xr(word_t'(rd_r[2*OutBits-1:OutBits])), .xi(word_t'(rd_r[OutBits-1:0])),
    .ur(ur_r), .ui(ui_r), .ar(ar), .ai(ai), .br(br), .bi(bi)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (in_ch.valid && cnt_r + 1'b1 == npts) begin
        state_nxt = (leff == 3'd0) ? ST_OUT : ST_RDU;
      end
      ST_RDU: state_nxt = ST_RDX;
      ST_RDX: state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_WRU;
      ST_WRU: state_nxt = ST_WRX;
      ST_WRX: if (bf_r == AddrBits'((npts >> 1) - 1'b1) && stage_r == leff - 3'd1) begin
        state_nxt = ST_OUT;
      end else begin
        state_nxt = ST_RDU;
      end
      ST_OUT: if (pend_last_r && !rd_pend_r && (!ov_r || out_ch.ready)) begin
        state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
    if (cfg_we && (cfg_index == CfgLog2 || cfg_index == CfgInv)) state_nxt = ST_LOAD;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    stage_nxt = stage_r;
    bf_nxt = bf_r;
    if (state_r == ST_LOAD && in_ch.valid) cnt_nxt = cnt_r + 1'b1;
    if (state_r == ST_WRX) begin
      if (bf_r == AddrBits'((npts >> 1) - 1'b1)) begin
        bf_nxt = '0;
        stage_nxt = stage_r + 3'd1;
      end else begin
        bf_nxt = bf_r + 1'b1;
      end
    end
    if (state_nxt == ST_LOAD && state_r != ST_LOAD) cnt_nxt = '0;
    if (state_r == ST_LOAD && state_nxt != ST_LOAD) begin
      stage_nxt = '0;
      bf_nxt = '0;
    end
    if (cfg_we && (cfg_index == CfgLog2 || cfg_index == CfgInv)) cnt_nxt = '0;
  end

  assign in_ch.ready = (state_r == ST_LOAD);

  logic issue_rd;
  assign issue_rd = (state_r == ST_OUT) && !pend_last_r && !rd_pend_r &&
                    (!ov_r || out_ch.ready);

  always_comb begin
    mem_we = 1'b0;
    mem_addr = ua;
    mem_wd = {ar, ai};
    unique case (state_r)
      ST_LOAD: begin
        mem_we = in_ch.valid;
        mem_addr = bit_rev(cnt_r[AddrBits-1:0], leff);
        mem_wd = {word_t'(in_ch.in_re),
                  inv_r ? -word_t'(in_ch.in_im) : word_t'(in_ch.in_im)};
      end
      ST_RDU: mem_addr = ua;
      ST_RDX: mem_addr = xa;
      ST_WRU: begin mem_we = 1'b1; mem_addr = ua; mem_wd = {ar, ai}; end
      ST_WRX: begin mem_we = 1'b1; mem_addr = xa; mem_wd = {br, bi}; end
      ST_OUT: mem_addr = oidx_r[AddrBits-1:0];
      default: mem_addr = ua;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rd_r <= mem[mem_addr];
    if (state_r == ST_RDX) begin
      ur_r <= word_t'(rd_r[2*OutBits-1:OutBits]);
      ui_r <= word_t'(rd_r[OutBits-1:0]);
    end
  end

  assign yr = inv_r ? (word_t'(rd_r[2*OutBits-1:OutBits]) >>> leff)
                    : word_t'(rd_r[2*OutBits-1:OutBits]);
  assign yi = inv_r ? word_t'((-word_t'(rd_r[OutBits-1:0])) >>> leff)
                    : word_t'(rd_r[OutBits-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r <= '0;
      stage_r <= '0;
      bf_r <= '0;
      log2_r <= 3'd6;
      inv_r <= 1'b0;
      rd_pend_r <= 1'b0;
      oidx_r <= '0;
      ov_r <= 1'b0;
      pend_last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      stage_r <= stage_nxt;
      bf_r <= bf_nxt;
      if (cfg_we && cfg_index == CfgLog2) log2_r <= cfg_data;
      if (cfg_we && cfg_index == CfgInv) inv_r <= cfg_data[0];
      rd_pend_r <= issue_rd;
      if (rd_pend_r) begin
        ov_r <= 1'b1;
        ore_r <= yr;
        oim_r <= yi;
        olast_r <= (oidx_r == npts);
        if (oidx_r == npts) pend_last_r <= 1'b1;
      end else if (ov_r && out_ch.ready) begin
        ov_r <= 1'b0;
      end
      if (state_r == ST_OUT && state_nxt == ST_LOAD) begin
        oidx_r <= '0;
        pend_last_r <= 1'b0;
      end else if (issue_rd) begin
        oidx_r <= oidx_r + 1'b1;
      end
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.out_re = ore_r;
  assign out_ch.out_im = oim_r;
  assign out_ch.out_last = olast_r;
endmodule
`default_nettype wire

[hdl/r2fft_checker.sv]
// Port-level assertions for the FFT core, bound to the top level.
`default_nettype none
module r2fft_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("out beat dropped");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("loading while emitting");
  a_last_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid) else $error("beat after last");
endmodule

bind radix2_fft_core r2fft_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.out_last)
);
`default_nettype wire
